// ----- rtl/core/cramt_pkg.sv -----
// Shared types, constants and saturating arithmetic for the circular range add / min tree.
// No dependencies; the top level, the walker and the testbench import this package.
package cramt_pkg;

  localparam int CFG_W  = 11;
  localparam int IDX_W  = 10;
  localparam int ELEM_W = 32;
  localparam int VAL_W  = 64;

  localparam logic [CFG_W-1:0] ELEMS_RESET = 11'd1024;

  localparam logic signed [VAL_W-1:0] VAL_MAX = 64'sh7fff_ffff_ffff_ffff;
  localparam logic signed [VAL_W-1:0] VAL_MIN = 64'sh8000_0000_0000_0000;

  typedef enum logic [1:0] {
    ACT_LOAD  = 2'd0,
    ACT_BUILD = 2'd1,
    ACT_ADD   = 2'd2,
    ACT_QUERY = 2'd3
  } action_t;

  typedef struct packed {
    action_t                    action;
    logic [IDX_W-1:0]           range_start;
    logic [IDX_W-1:0]           range_end;
    logic signed [ELEM_W-1:0]   operand_value;
  } cmd_word_t;

  typedef struct packed {
    logic signed [VAL_W-1:0]    min_value;
    logic                       error;
  } rsp_word_t;

  typedef struct packed {
    logic signed [VAL_W-1:0]    nmin;
    logic signed [VAL_W-1:0]    pend;
  } node_t;

  function automatic logic signed [VAL_W-1:0] sat_add(input logic signed [VAL_W-1:0] x,
                                                      input logic signed [VAL_W-1:0] y);
    logic signed [VAL_W-1:0] s;
    s = x + y;
    if (x[VAL_W-1] == y[VAL_W-1] && s[VAL_W-1] != x[VAL_W-1]) begin
      s = y[VAL_W-1] ? VAL_MIN : VAL_MAX;
    end
    return s;
  endfunction

  function automatic logic signed [VAL_W-1:0] min_val(input logic signed [VAL_W-1:0] x,
                                                      input logic signed [VAL_W-1:0] y);
    return (x < y) ? x : y;
  endfunction

endpackage

// ----- rtl/core/circular_range_add_min_tree_top.sv -----
// Top level: element-count register with clamping, and the tree walker with its RAMs.
// Depends on cramt_pkg and cramt_walk.
//
//  port group            dir  handshake
//  cmd / start / busy    in   word taken when start=1 and busy=0
//  rsp / done            out  word valid for the single cycle done=1, no backpressure
//  cfg_we / cfg_data     in   count register written when cfg_we=1
//
// Load writes one element. Build visits every tree node; add and query visit the nodes
// their range reaches, with a read-modify-write of the node RAM per visited node, and a
// wrapped range takes a second pass from index 0.
// Reset clears control only; the tree must be built before any add or query.
// One word at a time: busy stays high until the word's result, if any, is shown.
module circular_range_add_min_tree_top #(
  parameter int MAX_ELEMS  = 1024,
  parameter int TREE_NODES = 2048
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  output logic                              busy,
  input  cramt_pkg::cmd_word_t              cmd,
  output logic                              done,
  output cramt_pkg::rsp_word_t              rsp,
  input  logic                              cfg_we,
  input  logic [cramt_pkg::CFG_W-1:0]       cfg_data
);
  import cramt_pkg::*;

  localparam int CW = $clog2(MAX_ELEMS + 1);

  logic [CFG_W-1:0] elems_in_use;
  logic [CW-1:0]    n;

  always_ff @(posedge clk) begin
    if (rst) begin
      elems_in_use <= ELEMS_RESET;
    end else if (cfg_we) begin
      elems_in_use <= cfg_data;
    end
  end

  always_comb begin
    if (elems_in_use == '0) begin
      n = CW'(1);
    end else if (32'(elems_in_use) > MAX_ELEMS) begin
      n = CW'(MAX_ELEMS);
    end else begin
      n = CW'(elems_in_use);
    end
  end

  cramt_walk #(.MAX_ELEMS(MAX_ELEMS), .TREE_NODES(TREE_NODES)) u_walk (
    .clk(clk), .rst(rst), .go(start), .item(cmd), .n(n),
    .busy(busy), .done(done), .result(rsp)
  );

endmodule

// ----- rtl/core/cramt_ram.sv -----
// Simple dual-port synchronous RAM: one write port, one read port, registered read data.
// No dependencies.
module cramt_ram #(
  parameter int W = 64,
  parameter int D = 1024,
  localparam int AW = $clog2(D)
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [W-1:0]  wdata,
  input  logic [AW-1:0] raddr,
  output logic [W-1:0]  rdata
);

  logic [W-1:0] mem [D];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/core/cramt_walk.sv -----
// Tree walker: explicit node stack driving read-modify-write passes over the node RAM.
// Depends on cramt_pkg and cramt_ram (node RAM and element RAM).
module cramt_walk #(
  parameter int MAX_ELEMS  = 1024,
  parameter int TREE_NODES = 2048,
  localparam int CW = $clog2(MAX_ELEMS + 1)
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 go,
  input  cramt_pkg::cmd_word_t item,
  input  logic [CW-1:0]        n,
  output logic                 busy,
  output logic                 done,
  output cramt_pkg::rsp_word_t result
);
  import cramt_pkg::*;

  localparam int KW  = (CW > IDX_W) ? CW : IDX_W;
  localparam int NW  = $clog2(TREE_NODES + 2 * MAX_ELEMS);
  localparam int AW  = $clog2(TREE_NODES);
  localparam int EAW = $clog2(MAX_ELEMS);
  localparam int SD  = $clog2(MAX_ELEMS) + 2;
  localparam int SPW = $clog2(SD + 1);
  localparam int SIW = $clog2(SD);
  localparam int NODE_W = 2 * VAL_W;

  typedef enum logic [3:0] {
    S_IDLE, S_CHECK, S_VISIT, S_LEAF, S_NODE, S_CL, S_CR, S_DEC, S_ML, S_MR
  } state_t;

  typedef struct packed {
    logic [KW-1:0] lo;
    logic [KW-1:0] hi;
    logic [NW-1:0] idx;
    logic [1:0]    phase;
  } frame_t;

  state_t                  state;
  cmd_word_t               item_r;
  frame_t                  stk [SD];
  frame_t                  top, root;
  logic [SPW-1:0]          sp;
  logic [KW-1:0]           a, b;
  logic                    wrap, pass2, cadd_r;
  logic signed [VAL_W-1:0] acc, p_r, lmin;

  // node and element RAM ports
  logic              n_we;
  logic [AW-1:0]     n_waddr, n_raddr;
  node_t             n_wdata, n_rd;
  logic [NODE_W-1:0] n_rdata;
  logic              e_we;
  logic [EAW-1:0]    e_waddr;
  logic [ELEM_W-1:0] e_rdata;

  cramt_ram #(.W(NODE_W), .D(TREE_NODES)) u_node_ram (
    .clk(clk), .we(n_we), .waddr(n_waddr), .wdata(n_wdata),
    .raddr(n_raddr), .rdata(n_rdata)
  );

  cramt_ram #(.W(ELEM_W), .D(MAX_ELEMS)) u_elem_ram (
    .clk(clk), .we(e_we), .waddr(e_waddr), .wdata(item_r.operand_value),
    .raddr(top.lo[EAW-1:0]), .rdata(e_rdata)
  );

  // top-of-stack decode
  logic [SIW-1:0]          tix, pix;
  logic [KW:0]             lh_sum;
  logic [KW-1:0]           mid, nm1, s_k, e_k;
  logic [NW-1:0]           lc, rc;
  logic                    leaf, disj, cov, ok_idx, ok_lc, ok_rc;
  logic                    s_bad, e_bad, do_pop;
  logic signed [VAL_W-1:0] v, p, m, fin, acc_upd, elem_ext;
  logic                    cov_add, cadj;

  function automatic logic signed [VAL_W-1:0] child_adj(input logic signed [VAL_W-1:0] x,
                                                        input logic signed [VAL_W-1:0] pp,
                                                        input logic                    ca,
                                                        input logic signed [VAL_W-1:0] vv);
    logic signed [VAL_W-1:0] t;
    t = (pp != '0) ? sat_add(x, pp) : x;
    return ca ? sat_add(t, vv) : t;
  endfunction

  always_comb begin
    tix      = SIW'(sp - SPW'(1));
    pix      = sp[SIW-1:0];
    top      = stk[tix];
    lh_sum   = {1'b0, top.lo} + {1'b0, top.hi};
    mid      = lh_sum[KW:1];
    lc       = top.idx + NW'(1);
    rc       = top.idx + NW'({KW'(mid - top.lo + KW'(1)), 1'b0});
    leaf     = (top.lo == top.hi);
    disj     = (top.hi < a) || (top.lo > b);
    cov      = (a <= top.lo) && (top.hi <= b);
    ok_idx   = top.idx < NW'(TREE_NODES);
    ok_lc    = lc < NW'(TREE_NODES);
    ok_rc    = rc < NW'(TREE_NODES);
    nm1      = KW'(n) - KW'(1);
    s_k      = KW'(item_r.range_start);
    e_k      = KW'(item_r.range_end);
    s_bad    = s_k >= KW'(n);
    e_bad    = e_k >= KW'(n);
    root     = '{lo: '0, hi: nm1, idx: '0, phase: 2'd0};
    v        = {{(VAL_W-ELEM_W){item_r.operand_value[ELEM_W-1]}}, item_r.operand_value};
    elem_ext = {{(VAL_W-ELEM_W){e_rdata[ELEM_W-1]}}, e_rdata};
    n_rd     = node_t'(n_rdata);
    p        = n_rd.pend;
    m        = (p != '0) ? sat_add(n_rd.nmin, p) : n_rd.nmin;
    cov_add  = (item_r.action == ACT_ADD) && cov && (v != '0);
    fin      = cov_add ? sat_add(m, v) : m;
    cadj     = !leaf && ((p != '0) || cov_add);
    acc_upd  = (state == S_VISIT && top.phase == 2'd0 && !ok_idx &&
                item_r.action == ACT_QUERY) ? min_val(acc, '0) : acc;

    n_raddr = (state == S_VISIT && top.phase != 2'd2) ? top.idx[AW-1:0] :
              (state == S_CL || state == S_ML) ? rc[AW-1:0] : lc[AW-1:0];
    n_we    = 1'b0;
    n_waddr = top.idx[AW-1:0];
    n_wdata = '{nmin: fin, pend: '0};
    unique case (state)
      S_LEAF: begin
        n_we    = 1'b1;
        n_wdata = '{nmin: elem_ext, pend: '0};
      end
      S_NODE: n_we = 1'b1;
      S_CL: begin
        n_we    = ok_lc;
        n_waddr = lc[AW-1:0];
        n_wdata = '{nmin: n_rd.nmin, pend: child_adj(n_rd.pend, p_r, cadd_r, v)};
      end
      S_CR: begin
        n_we    = ok_rc;
        n_waddr = rc[AW-1:0];
        n_wdata = '{nmin: n_rd.nmin, pend: child_adj(n_rd.pend, p_r, cadd_r, v)};
      end
      S_MR: begin
        n_we    = 1'b1;
        n_wdata = '{nmin: min_val(lmin, ok_rc ? n_rd.nmin : '0), pend: '0};
      end
      default: n_we = 1'b0;
    endcase

    e_we    = (state == S_CHECK) && (item_r.action == ACT_LOAD) && !s_bad;
    e_waddr = EAW'(item_r.range_start);

    do_pop = (state == S_VISIT && top.phase == 2'd0 && !ok_idx) ||
             (state == S_VISIT && top.phase == 2'd2 && item_r.action == ACT_QUERY) ||
             (state == S_LEAF) || (state == S_MR) ||
             (state == S_DEC && (disj || cov));
  end

  assign busy = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      sp    <= '0;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_IDLE: if (go) begin
          item_r <= item;
          state  <= S_CHECK;
        end
        S_CHECK: begin
          unique case (item_r.action)
            ACT_LOAD: begin
              if (s_bad) begin
                done   <= 1'b1;
                result <= '{min_value: '0, error: 1'b1};
              end
              state <= S_IDLE;
            end
            ACT_BUILD: begin
              a      <= '0;
              b      <= nm1;
              wrap   <= 1'b0;
              pass2  <= 1'b0;
              stk[0] <= root;
              sp     <= SPW'(1);
              state  <= S_VISIT;
            end
            default: begin
              if (s_bad || e_bad) begin
                done   <= 1'b1;
                result <= '{min_value: '0, error: 1'b1};
                state  <= S_IDLE;
              end else begin
                wrap   <= s_k > e_k;
                a      <= s_k;
                b      <= (s_k > e_k) ? nm1 : e_k;
                acc    <= VAL_MAX;
                pass2  <= 1'b0;
                stk[0] <= root;
                sp     <= SPW'(1);
                state  <= S_VISIT;
              end
            end
          endcase
        end
        S_VISIT: begin
          acc <= acc_upd;
          priority if (top.phase == 2'd0) begin
            if (ok_idx) begin
              if (item_r.action != ACT_BUILD) begin
                state <= S_NODE;
              end else if (leaf) begin
                state <= S_LEAF;
              end else begin
                stk[tix].phase <= 2'd1;
                stk[pix]       <= '{lo: top.lo, hi: mid, idx: lc, phase: 2'd0};
                sp             <= sp + SPW'(1);
              end
            end
          end else if (top.phase == 2'd1) begin
            stk[tix].phase <= 2'd2;
            stk[pix]       <= '{lo: mid + KW'(1), hi: top.hi, idx: rc, phase: 2'd0};
            sp             <= sp + SPW'(1);
          end else begin
            if (item_r.action != ACT_QUERY) begin
              state <= S_ML;
            end
          end
        end
        S_LEAF: state <= S_VISIT;
        S_NODE: begin
          p_r    <= p;
          cadd_r <= cov_add;
          if (item_r.action == ACT_QUERY && cov) begin
            acc <= min_val(acc, m);
          end
          state <= cadj ? S_CL : S_DEC;
        end
        S_CL: state <= S_CR;
        S_CR: state <= S_DEC;
        S_DEC: begin
          if (!(disj || cov)) begin
            stk[tix].phase <= 2'd1;
            stk[pix]       <= '{lo: top.lo, hi: mid, idx: lc, phase: 2'd0};
            sp             <= sp + SPW'(1);
          end
          state <= S_VISIT;
        end
        S_ML: begin
          lmin  <= ok_lc ? n_rd.nmin : '0;
          state <= S_MR;
        end
        S_MR: state <= S_VISIT;
      endcase

      if (do_pop) begin
        if (sp == SPW'(1)) begin
          if (item_r.action != ACT_BUILD && wrap && !pass2) begin
            pass2  <= 1'b1;
            a      <= '0;
            b      <= e_k;
            stk[0] <= root;
            state  <= S_VISIT;
          end else begin
            sp    <= '0;
            state <= S_IDLE;
            if (item_r.action == ACT_QUERY) begin
              done   <= 1'b1;
              result <= '{min_value: acc_upd, error: 1'b0};
            end
          end
        end else begin
          sp    <= sp - SPW'(1);
          state <= S_VISIT;
        end
      end
    end
  end

endmodule

// ----- verif/tb_circular_range_add_min_tree_top.sv -----
// Testbench for circular_range_add_min_tree_top: loads, builds, circular range adds and
// minimum queries checked against a lazy min-tree predictor. Depends on cramt_pkg and the RTL.
module tb_circular_range_add_min_tree_top;
  timeunit 1ns;
  timeprecision 1ps;
  import cramt_pkg::*;

  localparam int NELEM = 1024;
  localparam int NNODE = 2048;
  localparam int STALL_LIMIT = 60000;
  localparam longint SUM_MAX = 64'sh7fff_ffff_ffff_ffff;
  localparam longint SUM_MIN = 64'sh8000_0000_0000_0000;

  logic clk;
  logic rst;
  logic start;
  logic busy;
  cmd_word_t cmd;
  logic done;
  rsp_word_t rsp;
  logic cfg_we;
  logic [CFG_W-1:0] cfg_data;

  circular_range_add_min_tree_top uut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .cmd(cmd),
    .done(done), .rsp(rsp), .cfg_we(cfg_we), .cfg_data(cfg_data)
  );

  longint elem_val[NELEM];
  longint node_min[NNODE];
  longint node_add[NNODE];
  bit elem_loaded[NELEM];
  logic [CFG_W-1:0] count_reg;
  rsp_word_t answers_due[$];
  int mismatches, words_sent, queries_seen, error_words, stall_cycles;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic longint clamp_sum(longint a, longint b);
    if (b > 0 && a > SUM_MAX - b) return SUM_MAX;
    if (b < 0 && a < SUM_MIN - b) return SUM_MIN;
    return a + b;
  endfunction

  function automatic longint lesser(longint a, longint b);
    return (a < b) ? a : b;
  endfunction

  function automatic longint node_rd(int unsigned i);
    return (i < NNODE) ? node_min[i] : 0;
  endfunction

  function automatic int unsigned right_of(int unsigned i, int unsigned lo, int unsigned mid);
    return i + 2 * (mid - lo + 1);
  endfunction

  function automatic void push_down(int unsigned lo, int unsigned hi, int unsigned i);
    longint p;
    int unsigned mid, rc;
    if (i >= NNODE) return;
    p = node_add[i];
    if (p == 0) return;
    node_min[i] = clamp_sum(node_min[i], p);
    if (lo != hi) begin
      mid = (lo + hi) / 2;
      rc = right_of(i, lo, mid);
      if (i + 1 < NNODE) node_add[i+1] = clamp_sum(node_add[i+1], p);
      if (rc < NNODE) node_add[rc] = clamp_sum(node_add[rc], p);
    end
    node_add[i] = 0;
  endfunction

  function automatic void build_nodes(int unsigned lo, int unsigned hi, int unsigned i);
    int unsigned mid, rc;
    if (i >= NNODE) return;
    node_add[i] = 0;
    if (lo == hi) begin
      node_min[i] = (lo < NELEM) ? elem_val[lo] : 0;
      return;
    end
    mid = (lo + hi) / 2;
    rc = right_of(i, lo, mid);
    build_nodes(lo, mid, i + 1);
    build_nodes(mid + 1, hi, rc);
    node_min[i] = lesser(node_rd(i + 1), node_rd(rc));
  endfunction

  function automatic void add_span(int unsigned lo, int unsigned hi, int unsigned i,
                                   int unsigned a, int unsigned b, longint v);
    int unsigned mid, rc;
    if (i >= NNODE) return;
    push_down(lo, hi, i);
    if (hi < a || lo > b) return;
    if (a <= lo && hi <= b) begin
      node_add[i] = clamp_sum(node_add[i], v);
      push_down(lo, hi, i);
      return;
    end
    mid = (lo + hi) / 2;
    rc = right_of(i, lo, mid);
    add_span(lo, mid, i + 1, a, b, v);
    add_span(mid + 1, hi, rc, a, b, v);
    node_min[i] = lesser(node_rd(i + 1), node_rd(rc));
  endfunction

  function automatic longint min_span(int unsigned lo, int unsigned hi, int unsigned i,
                                      int unsigned a, int unsigned b);
    int unsigned mid;
    if (i >= NNODE) return 0;
    push_down(lo, hi, i);
    if (hi < a || lo > b) return SUM_MAX;
    if (a <= lo && hi <= b) return node_min[i];
    mid = (lo + hi) / 2;
    return lesser(min_span(lo, mid, i + 1, a, b),
                  min_span(mid + 1, hi, right_of(i, lo, mid), a, b));
  endfunction

  function automatic int unsigned live_count();
    if (count_reg == 0) return 1;
    if (count_reg > NELEM) return NELEM;
    return count_reg;
  endfunction

  function automatic void predict_word(cmd_word_t c);
    int unsigned n, s, e;
    longint v, m;
    rsp_word_t r;
    n = live_count();
    s = c.range_start;
    e = c.range_end;
    v = longint'(c.operand_value);
    r.min_value = '0;
    r.error = 1'b1;
    if (c.action == ACT_BUILD) begin
      build_nodes(0, n - 1, 0);
      return;
    end
    if (c.action == ACT_LOAD) begin
      if (s >= n) answers_due.push_back(r);
      else elem_val[s] = v;
      return;
    end
    if (s >= n || e >= n) begin
      answers_due.push_back(r);
      return;
    end
    if (c.action == ACT_ADD) begin
      if (s <= e) add_span(0, n - 1, 0, s, e, v);
      else begin
        add_span(0, n - 1, 0, s, n - 1, v);
        add_span(0, n - 1, 0, 0, e, v);
      end
      return;
    end
    if (s <= e) m = min_span(0, n - 1, 0, s, e);
    else m = lesser(min_span(0, n - 1, 0, s, n - 1), min_span(0, n - 1, 0, 0, e));
    r.min_value = m;
    r.error = 1'b0;
    answers_due.push_back(r);
  endfunction

  task automatic send_word(action_t act, int s, int e, logic signed [31:0] v);
    cmd_word_t c;
    c.action = act;
    c.range_start = s[IDX_W-1:0];
    c.range_end = e[IDX_W-1:0];
    c.operand_value = v;
    start <= 1'b1;
    cmd <= c;
    do @(posedge clk); while (busy);
    if (act == ACT_LOAD && c.range_start < live_count()) elem_loaded[c.range_start] = 1'b1;
    predict_word(c);
    words_sent++;
  endtask

  task automatic idle_gap();
    int g;
    int pick;
    pick = $urandom_range(99, 0);
    if (pick < 55) g = 0;
    else if (pick < 93) g = $urandom_range(3, 1);
    else g = $urandom_range(40, 8);
    if (g > 0) begin
      start <= 1'b0;
      repeat (g) @(posedge clk);
    end
  endtask

  task automatic drain();
    start <= 1'b0;
    do @(posedge clk); while (busy || answers_due.size() != 0);
  endtask

  task automatic set_count(int v);
    drain();
    cfg_we <= 1'b1;
    cfg_data <= v[CFG_W-1:0];
    @(posedge clk);
    cfg_we <= 1'b0;
    count_reg = v[CFG_W-1:0];
  endtask

  task automatic load_and_build();
    int n;
    n = live_count();
    for (int k = 0; k < n; k++) begin
      if (!elem_loaded[k]) send_word(ACT_LOAD, k, 0, $urandom());
    end
    send_word(ACT_BUILD, 0, 0, 0);
  endtask

  function automatic int pick_index(int n);
    return ($urandom_range(9, 0) == 0) ? $urandom_range(NELEM - 1, 0) : $urandom_range(n - 1, 0);
  endfunction

  task automatic random_word();
    int n, pick;
    logic signed [31:0] v;
    n = live_count();
    pick = $urandom_range(99, 0);
    v = ($urandom_range(3, 0) == 0) ? $urandom() : $signed($urandom_range(2000, 0)) - 1000;
    if (pick < 15) send_word(ACT_LOAD, pick_index(n), $urandom_range(NELEM - 1, 0), v);
    else if (pick < 20) send_word(ACT_BUILD, $urandom_range(NELEM - 1, 0),
                                  $urandom_range(NELEM - 1, 0), $urandom());
    else if (pick < 55) send_word(ACT_ADD, pick_index(n), pick_index(n), v);
    else send_word(ACT_QUERY, pick_index(n), pick_index(n), $urandom());
    idle_gap();
  endtask

  task automatic test_directed();
    set_count(16);
    for (int k = 0; k < 16; k++) send_word(ACT_LOAD, k, 0, k * 3 - 20);
    send_word(ACT_LOAD, 5, 0, 32'sh7fff_ffff);
    send_word(ACT_LOAD, 9, 0, 32'sh8000_0000);
    send_word(ACT_BUILD, 0, 0, 0);
    send_word(ACT_QUERY, 0, 15, 0);
    send_word(ACT_QUERY, 5, 5, 0);
    send_word(ACT_QUERY, 12, 3, 0);
    send_word(ACT_ADD, 10, 2, 32'sh7fff_ffff);
    send_word(ACT_ADD, 4, 11, 32'sh8000_0000);
    send_word(ACT_QUERY, 14, 1, 0);
    send_word(ACT_QUERY, 3, 12, 0);
    send_word(ACT_LOAD, 16, 0, 7);
    send_word(ACT_ADD, 2, 16, 7);
    send_word(ACT_QUERY, 1023, 0, 0);
    send_word(ACT_QUERY, 0, 1023, 0);
    send_word(ACT_QUERY, 7, 7, 0);
  endtask

  task automatic test_count_extremes();
    set_count(0);
    load_and_build();
    send_word(ACT_QUERY, 0, 0, 0);
    send_word(ACT_ADD, 0, 0, -5);
    send_word(ACT_QUERY, 0, 0, 0);
    send_word(ACT_QUERY, 1, 0, 0);
    set_count(37);
    load_and_build();
    repeat (30) random_word();
    set_count(20);
    repeat (30) random_word();
  endtask

  task automatic test_random_phases();
    int n;
    for (int p = 0; p < 12; p++) begin
      n = ($urandom_range(4, 0) == 0) ? $urandom_range(300, 65) : $urandom_range(64, 1);
      set_count(n);
      load_and_build();
      repeat (55) begin
        random_word();
      end
      if (p == 5) drain();
    end
  endtask

  always @(posedge clk) begin
    if (rst || (start && !busy) || done) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
    if (stall_cycles > STALL_LIMIT) begin
      $display("tb_circular_range_add_min_tree_top: done, errors");
      $finish;
    end
  end

  always @(posedge clk) begin
    rsp_word_t want;
    if (!rst && done) begin
      if (answers_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected word: min %0d err %0b", rsp.min_value, rsp.error);
      end else begin
        want = answers_due.pop_front();
        if (!rsp.error) queries_seen++;
        else error_words++;
        if (rsp.min_value !== want.min_value || rsp.error !== want.error) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: want min %0d err %0b, got min %0d err %0b",
                     want.min_value, want.error, rsp.min_value, rsp.error);
        end
      end
    end
  end

  initial begin
    rst = 1'b1;
    start = 1'b0;
    cmd = '0;
    cfg_we = 1'b0;
    cfg_data = '0;
    count_reg = ELEMS_RESET;
    mismatches = 0;
    words_sent = 0;
    queries_seen = 0;
    error_words = 0;
    stall_cycles = 0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_count_extremes();
    test_random_phases();
    drain();
    repeat (20) @(posedge clk);
    if (answers_due.size() != 0) mismatches++;
    $display("sent %0d words; %0d query minimums and %0d error words checked",
             words_sent, queries_seen, error_words);
    if (mismatches == 0) begin
      $display("tb_circular_range_add_min_tree_top: done, clean");
    end else begin
      $display("tb_circular_range_add_min_tree_top: done, errors");
    end
    $finish;
  end
endmodule
